// File: hw/rtl/urfp_pkg.sv
// ----------------------------------------------------------------------------
// urfp_pkg
// Types and constants shared by the UART receive frame parser FIFO.
// ----------------------------------------------------------------------------
package urfp_pkg;

  localparam logic [7:0] START_MARK = 8'hFF;

  localparam int unsigned MQ_DEPTH = 2;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_RX        = 2'd0,
    CMD_POP       = 2'd1,
    CMD_READ_DIST = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ITEM_RX,
    ITEM_HW_ERR,
    ITEM_POP,
    ITEM_READ,
    ITEM_NONE
  } item_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_FRAMING  = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_PARITY   = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_code_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_SUM  = 2'd3
  } phase_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
    logic       start;
    logic       frame_err;
    logic       overrun_err;
    logic       parity_err;
    err_code_e  hw_code;
  } item_t;

  typedef struct packed {
    logic        read_valid;
    logic [7:0]  read_byte;
    logic [15:0] distance;
    logic        distance_ready;
    err_code_e   recent_err;
    logic [15:0] error_total;
    logic [15:0] framing_total;
    logic [15:0] overflow_total;
    logic [15:0] parity_total;
    logic [15:0] received_total;
    logic        error_event;
    logic [6:0]  fifo_level;
  } result_t;

endpackage

// File: hw/rtl/urfp_queue.sv
// ----------------------------------------------------------------------------
// urfp_queue
// Small register queue used between the front and back parts and on the
// result side.
// ----------------------------------------------------------------------------
module urfp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/urfp_front.sv
// ----------------------------------------------------------------------------
// urfp_front
// Classifies each incoming beat: receive error screening with priority,
// start mark detection and command decode.
// ----------------------------------------------------------------------------
module urfp_front (
  input  logic           [1:0] cmd_i,
  input  logic           [7:0] rx_byte_i,
  input  logic                 frame_error_i,
  input  logic                 overrun_error_i,
  input  logic                 parity_error_i,
  output urfp_pkg::item_t      item_o
);

  import urfp_pkg::*;

  logic any_err;

  assign any_err = frame_error_i || overrun_error_i || parity_error_i;

  always_comb begin
    item_o.data        = rx_byte_i;
    item_o.start       = (rx_byte_i == START_MARK);
    item_o.frame_err   = frame_error_i;
    item_o.overrun_err = overrun_error_i;
    item_o.parity_err  = parity_error_i;

    if (parity_error_i) begin
      item_o.hw_code = ERR_PARITY;
    end else if (overrun_error_i) begin
      item_o.hw_code = ERR_OVERFLOW;
    end else if (frame_error_i) begin
      item_o.hw_code = ERR_FRAMING;
    end else begin
      item_o.hw_code = ERR_NONE;
    end

    case (cmd_e'(cmd_i))
      CMD_RX: begin
        item_o.kind = any_err ? ITEM_HW_ERR : ITEM_RX;
      end
      CMD_POP:       item_o.kind = ITEM_POP;
      CMD_READ_DIST: item_o.kind = ITEM_READ;
      default:       item_o.kind = ITEM_NONE;
    endcase
  end

endmodule

// File: hw/rtl/urfp_back.sv
// ----------------------------------------------------------------------------
// urfp_back
// Executes classified items: error statistics, raw byte ring buffer and
// sensor frame parser; a second stage joins the buffer read data.
// ----------------------------------------------------------------------------
module urfp_back #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_data_i,
  input  logic                 item_valid_i,
  input  urfp_pkg::item_t      item_i,
  input  logic                 room_i,
  output logic                 item_pop_o,
  output logic                 res_valid_o,
  output urfp_pkg::result_t    res_o
);

  import urfp_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

  logic [7:0]       mem_q [FIFO_DEPTH];
  logic [7:0]       rdata_q;

  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [LVL_W-1:0] fill_q, fill_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       sum_q, sum_d;
  logic [15:0]      partial_q, partial_d;
  logic [15:0]      dist_q, dist_d;
  logic             ready_q, ready_d;
  logic             mode_q, mode_d;
  err_code_e        code_q, code_d;
  logic [15:0]      err_cnt_q, err_cnt_d;
  logic [15:0]      frm_cnt_q, frm_cnt_d;
  logic [15:0]      ovf_cnt_q, ovf_cnt_d;
  logic [15:0]      par_cnt_q, par_cnt_d;
  logic [15:0]      rcv_cnt_q, rcv_cnt_d;

  logic             s2_valid_q;
  result_t          s2_q, s2_d;

  logic             fire, is_byte, sensor_byte, raw_byte, fifo_full;
  logic             do_store, do_pop, sum_ok;

  assign fire        = item_valid_i && room_i;
  assign item_pop_o  = fire;
  assign is_byte     = fire && (item_i.kind == ITEM_RX);
  assign sensor_byte = is_byte && mode_q;
  assign raw_byte    = is_byte && !mode_q;
  assign fifo_full   = (fill_q >= LVL_W'(FIFO_DEPTH));
  assign do_store    = raw_byte && !fifo_full;
  assign do_pop      = fire && (item_i.kind == ITEM_POP) && (fill_q != '0);
  assign sum_ok      = (sum_q == item_i.data);

  // parser phase
  always_comb begin
    phase_d = phase_q;
    if (cfg_valid_i) begin
      phase_d = PH_HUNT;
    end else if (sensor_byte) begin
      case (phase_q)
        PH_HUNT: phase_d = item_i.start ? PH_HIGH : PH_HUNT;
        PH_HIGH: phase_d = PH_LOW;
        PH_LOW:  phase_d = PH_SUM;
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // datapath and statistics
  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    sum_d     = sum_q;
    partial_d = partial_q;
    dist_d    = dist_q;
    ready_d   = ready_q;
    mode_d    = mode_q;
    code_d    = code_q;
    err_cnt_d = err_cnt_q;
    frm_cnt_d = frm_cnt_q;
    ovf_cnt_d = ovf_cnt_q;
    par_cnt_d = par_cnt_q;
    rcv_cnt_d = rcv_cnt_q;
    s2_d      = '0;

    if (fire && (item_i.kind == ITEM_HW_ERR)) begin
      err_cnt_d = err_cnt_q + 16'd1;
      if (item_i.frame_err) begin
        frm_cnt_d = frm_cnt_q + 16'd1;
      end
      if (item_i.overrun_err) begin
        ovf_cnt_d = ovf_cnt_q + 16'd1;
      end
      if (item_i.parity_err) begin
        par_cnt_d = par_cnt_q + 16'd1;
      end
      code_d = item_i.hw_code;
      s2_d.error_event = 1'b1;
    end

    if (sensor_byte) begin
      case (phase_q)
        PH_HUNT: begin
          if (item_i.start) begin
            sum_d     = '0;
            rcv_cnt_d = rcv_cnt_q + 16'd1;
          end
        end
        PH_HIGH: begin
          partial_d = {item_i.data, 8'h00};
          sum_d     = sum_q + item_i.data;
          rcv_cnt_d = rcv_cnt_q + 16'd1;
        end
        PH_LOW: begin
          partial_d = partial_q | {8'h00, item_i.data};
          sum_d     = sum_q + item_i.data;
          rcv_cnt_d = rcv_cnt_q + 16'd1;
        end
        default: begin
          if (sum_ok) begin
            dist_d  = partial_q;
            ready_d = 1'b1;
          end else begin
            err_cnt_d        = err_cnt_q + 16'd1;
            code_d           = ERR_CHECKSUM;
            s2_d.error_event = 1'b1;
          end
        end
      endcase
    end

    if (raw_byte) begin
      if (fifo_full) begin
        ovf_cnt_d        = ovf_cnt_q + 16'd1;
        code_d           = ERR_OVERFLOW;
        s2_d.error_event = 1'b1;
      end else begin
        wp_d      = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
        fill_d    = fill_q + LVL_W'(1);
        rcv_cnt_d = rcv_cnt_q + 16'd1;
      end
    end

    if (do_pop) begin
      rp_d   = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
      fill_d = fill_q - LVL_W'(1);
    end

    s2_d.read_valid     = do_pop;
    s2_d.distance_ready = ready_d;
    s2_d.distance       = dist_d;
    s2_d.recent_err     = code_d;
    s2_d.error_total    = err_cnt_d;
    s2_d.framing_total  = frm_cnt_d;
    s2_d.overflow_total = ovf_cnt_d;
    s2_d.parity_total   = par_cnt_d;
    s2_d.received_total = rcv_cnt_d;
    s2_d.fifo_level     = 7'(fill_d);

    if (fire && (item_i.kind == ITEM_READ)) begin
      ready_d = 1'b0;
    end

    if (cfg_valid_i) begin
      mode_d    = cfg_data_i;
      sum_d     = '0;
      partial_d = '0;
      ready_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      phase_q    <= PH_HUNT;
      sum_q      <= '0;
      partial_q  <= '0;
      dist_q     <= '0;
      ready_q    <= 1'b0;
      mode_q     <= 1'b0;
      code_q     <= ERR_NONE;
      err_cnt_q  <= '0;
      frm_cnt_q  <= '0;
      ovf_cnt_q  <= '0;
      par_cnt_q  <= '0;
      rcv_cnt_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      partial_q  <= partial_d;
      dist_q     <= dist_d;
      ready_q    <= ready_d;
      mode_q     <= mode_d;
      code_q     <= code_d;
      err_cnt_q  <= err_cnt_d;
      frm_cnt_q  <= frm_cnt_d;
      ovf_cnt_q  <= ovf_cnt_d;
      par_cnt_q  <= par_cnt_d;
      rcv_cnt_q  <= rcv_cnt_d;
      s2_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem_q[wp_q] <= item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  assign res_valid_o = s2_valid_q;

  always_comb begin
    res_o           = s2_q;
    res_o.read_byte = s2_q.read_valid ? rdata_q : 8'h00;
  end

endmodule

// File: hw/rtl/uart_receive_frame_parser_fifo.sv
// ----------------------------------------------------------------------------
// uart_receive_frame_parser_fifo
// UART receive side: error screening, raw byte ring buffer and sensor
// distance frame parser, with queue style input and result ports.
// ----------------------------------------------------------------------------
// Result path: an accepted item is executed and registered together with
// its buffer read data, then written into the result queue.
// Throughput: one item per cycle while pop keeps up with the results.
// Reset: asynchronous; clears pointers, level, parser, flags, counters and
// queues at once. Buffer contents are left as they are.
// ----------------------------------------------------------------------------
module uart_receive_frame_parser_fifo #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_error_i,
  input  logic        overrun_error_i,
  input  logic        parity_error_i,
  output logic        empty,
  input  logic        pop,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o,
  output logic [15:0] distance_o,
  output logic        distance_ready_o,
  output logic [2:0]  recent_err_o,
  output logic [15:0] error_total_o,
  output logic [15:0] framing_total_o,
  output logic [15:0] overflow_total_o,
  output logic [15:0] parity_total_o,
  output logic [15:0] received_total_o,
  output logic        error_event_o,
  output logic [6:0]  fifo_level_o
);

  import urfp_pkg::*;

  item_t               front_item, mq_item;
  logic                mq_empty, mq_pop;
  logic                room;
  logic                res_valid;
  result_t             res, oq_res;
  logic [OQ_CNT_W-1:0] oq_count;

  assign cfg_ready_o = 1'b1;

  urfp_front u_front (
    .cmd_i           (cmd_i),
    .rx_byte_i       (rx_byte_i),
    .frame_error_i   (frame_error_i),
    .overrun_error_i (overrun_error_i),
    .parity_error_i  (parity_error_i),
    .item_o          (front_item)
  );

  urfp_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MQ_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mq_pop),
    .data_o  (mq_item),
    .empty_o (mq_empty),
    .count_o ()
  );

  assign room = (oq_count <= OQ_CNT_W'(OQ_DEPTH - 2));

  urfp_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (!mq_empty),
    .item_i       (mq_item),
    .room_i       (room),
    .item_pop_o   (mq_pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  urfp_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (oq_res),
    .empty_o (empty),
    .count_o (oq_count)
  );

  assign read_valid_o     = oq_res.read_valid;
  assign read_byte_o      = oq_res.read_byte;
  assign distance_o       = oq_res.distance;
  assign distance_ready_o = oq_res.distance_ready;
  assign recent_err_o     = oq_res.recent_err;
  assign error_total_o    = oq_res.error_total;
  assign framing_total_o  = oq_res.framing_total;
  assign overflow_total_o = oq_res.overflow_total;
  assign parity_total_o   = oq_res.parity_total;
  assign received_total_o = oq_res.received_total;
  assign error_event_o    = oq_res.error_event;
  assign fifo_level_o     = oq_res.fifo_level;

endmodule

// File: hw/rtl/urfp_checker.sv
// ----------------------------------------------------------------------------
// urfp_checker
// Port level checks for the UART receive frame parser FIFO.
// ----------------------------------------------------------------------------
module urfp_checker #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        read_valid_o,
  input logic [7:0]  read_byte_o,
  input logic [2:0]  recent_err_o,
  input logic [15:0] error_total_o,
  input logic        error_event_o,
  input logic [6:0]  fifo_level_o
);

  import urfp_pkg::*;

  a_reset_empty : assert property (@(posedge clk_i)
    !rst_ni |-> empty)
    else $error("result side not empty during reset");

  a_no_read_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !read_valid_o) |-> (read_byte_o == 8'h00))
    else $error("read byte nonzero without a pop");

  a_event_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_event_o) |-> (recent_err_o != ERR_NONE))
    else $error("error beat without an error code");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (FIFO_DEPTH < 128)) |-> (fifo_level_o <= 7'(FIFO_DEPTH)))
    else $error("buffer level beyond depth");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(error_total_o)))
    else $error("stalled result beat changed");

endmodule

bind uart_receive_frame_parser_fifo urfp_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_urfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .read_valid_o  (read_valid_o),
  .read_byte_o   (read_byte_o),
  .recent_err_o  (recent_err_o),
  .error_total_o (error_total_o),
  .error_event_o (error_event_o),
  .fifo_level_o  (fifo_level_o)
);

// File: tb/tb_uart_receive_frame_parser_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_receive_frame_parser_fifo
// Self-checking bench for the UART receive frame parser FIFO. A short
// directed table covers the reset state, every command, each error kind and
// its precedence, and good and bad distance frames. Random phases in raw and
// sensor mode follow. An in-bench model of the block predicts the status
// beat for every accepted event. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_uart_receive_frame_parser_fifo;
  import urfp_pkg::*;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned N_ROWS = 28;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       fe;
    logic       oe;
    logic       pe;
  } rx_item_t;

  // Mode, event fields, then the status typed in where it is plain to see.
  typedef struct packed {
    logic        mode;
    cmd_e        cmd;
    logic [7:0]  data;
    logic        fe;
    logic        oe;
    logic        pe;
    logic        typed;
    logic        vld;
    logic [7:0]  rbyte;
    logic [15:0] dist_val;
    logic        rdy;
    err_code_e   err;
    logic        evt;
    logic [6:0]  lvl;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  logic        push;
  logic        full;
  logic [1:0]  cmd_i;
  logic [7:0]  rx_byte_i;
  logic        frame_error_i;
  logic        overrun_error_i;
  logic        parity_error_i;
  logic        empty;
  logic        pop;
  logic        read_valid_o;
  logic [7:0]  read_byte_o;
  logic [15:0] distance_o;
  logic        distance_ready_o;
  logic [2:0]  recent_err_o;
  logic [15:0] error_total_o;
  logic [15:0] framing_total_o;
  logic [15:0] overflow_total_o;
  logic [15:0] parity_total_o;
  logic [15:0] received_total_o;
  logic        error_event_o;
  logic [6:0]  fifo_level_o;

  uart_receive_frame_parser_fifo #(
    .FIFO_DEPTH(DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .rx_byte_i       (rx_byte_i),
    .frame_error_i   (frame_error_i),
    .overrun_error_i (overrun_error_i),
    .parity_error_i  (parity_error_i),
    .empty           (empty),
    .pop             (pop),
    .read_valid_o    (read_valid_o),
    .read_byte_o     (read_byte_o),
    .distance_o      (distance_o),
    .distance_ready_o(distance_ready_o),
    .recent_err_o    (recent_err_o),
    .error_total_o   (error_total_o),
    .framing_total_o (framing_total_o),
    .overflow_total_o(overflow_total_o),
    .parity_total_o  (parity_total_o),
    .received_total_o(received_total_o),
    .error_event_o   (error_event_o),
    .fifo_level_o    (fifo_level_o)
  );

  // Receive model state
  logic [7:0]  ring [DEPTH];
  logic [5:0]  rd_ptr;
  logic [5:0]  wr_ptr;
  logic [6:0]  ring_level;
  phase_e      parse_ph;
  logic [7:0]  frame_sum;
  logic [15:0] frame_value;
  logic [15:0] dist_latch;
  logic        dist_ready;
  logic [15:0] cnt_err;
  logic [15:0] cnt_frm;
  logic [15:0] cnt_ovf;
  logic [15:0] cnt_par;
  logic [15:0] cnt_rcv;
  err_code_e   err_code;
  logic        sensor_on;

  result_t     pending_status [$];
  result_t     want;
  int          mismatches;
  int          sent_items;
  int          burst_left;

  dir_row_t dir_rows [N_ROWS] = '{
    '{'0, CMD_POP,       8'h00, '0, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'0, CMD_READ_DIST, 8'h00, '0, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'0, CMD_NONE,      8'hFF, '1, '1, '1, '1, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'0, CMD_RX,        8'h00, '0, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd1},
    '{'0, CMD_RX,        8'hFF, '0, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd2},
    '{'0, CMD_RX,        8'h3C, '1, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_FRAMING,  '1, 7'd2},
    '{'0, CMD_RX,        8'hC3, '0, '1, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_OVERFLOW, '1, 7'd2},
    '{'0, CMD_RX,        8'h5A, '0, '0, '1, '1, '0, 8'h00, 16'h0000, '0, ERR_PARITY,   '1, 7'd2},
    '{'0, CMD_RX,        8'hA5, '1, '1, '1, '1, '0, 8'h00, 16'h0000, '0, ERR_PARITY,   '1, 7'd2},
    '{'0, CMD_POP,       8'h00, '0, '0, '0, '1, '1, 8'h00, 16'h0000, '0, ERR_PARITY,   '0, 7'd1},
    '{'0, CMD_POP,       8'h00, '0, '0, '0, '1, '1, 8'hFF, 16'h0000, '0, ERR_PARITY,   '0, 7'd0},
    '{'0, CMD_POP,       8'h00, '0, '0, '0, '1, '0, 8'h00, 16'h0000, '0, ERR_PARITY,   '0, 7'd0},
    '{'0, CMD_RX,        8'h7E, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h55, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'hFF, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h12, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h34, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h46, '0, '0, '0, '1, '0, 8'h00, 16'h1234, '1, ERR_PARITY,   '0, 7'd1},
    '{'1, CMD_READ_DIST, 8'h00, '0, '0, '0, '1, '0, 8'h00, 16'h1234, '1, ERR_PARITY,   '0, 7'd1},
    '{'1, CMD_RX,        8'hFF, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'hFF, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'hFF, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'hFE, '0, '0, '0, '1, '0, 8'h00, 16'hFFFF, '1, ERR_PARITY,   '0, 7'd1},
    '{'1, CMD_RX,        8'hFF, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h00, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h00, '0, '0, '0, '0, '0, 8'h00, 16'h0000, '0, ERR_NONE,     '0, 7'd0},
    '{'1, CMD_RX,        8'h01, '0, '0, '0, '1, '0, 8'h00, 16'hFFFF, '1, ERR_CHECKSUM, '1, 7'd1},
    '{'1, CMD_POP,       8'h00, '0, '0, '0, '1, '1, 8'h7E, 16'hFFFF, '1, ERR_CHECKSUM, '0, 7'd0}
  };

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
  endtask

  task automatic clear_frame();
    parse_ph    = PH_HUNT;
    frame_sum   = '0;
    frame_value = '0;
    dist_ready  = 1'b0;
  endtask

  // Advance the model by one receive event and return the status beat.
  function automatic result_t predict_status(rx_item_t it);
    result_t r;
    logic    evt;
    logic    vld;
    logic    rdy;
    logic [7:0] got_byte;
    evt      = 1'b0;
    vld      = 1'b0;
    got_byte = '0;
    if (it.cmd == CMD_RX) begin
      if (it.fe || it.oe || it.pe) begin
        cnt_err = cnt_err + 16'd1;
        if (it.fe) begin
          cnt_frm  = cnt_frm + 16'd1;
          err_code = ERR_FRAMING;
        end
        if (it.oe) begin
          cnt_ovf  = cnt_ovf + 16'd1;
          err_code = ERR_OVERFLOW;
        end
        if (it.pe) begin
          cnt_par  = cnt_par + 16'd1;
          err_code = ERR_PARITY;
        end
        evt = 1'b1;
      end else if (sensor_on) begin
        case (parse_ph)
          PH_HUNT: begin
            if (it.data == START_MARK) begin
              parse_ph  = PH_HIGH;
              frame_sum = '0;
              cnt_rcv   = cnt_rcv + 16'd1;
            end
          end
          PH_HIGH: begin
            frame_value = {it.data, 8'h00};
            frame_sum   = frame_sum + it.data;
            parse_ph    = PH_LOW;
            cnt_rcv     = cnt_rcv + 16'd1;
          end
          PH_LOW: begin
            frame_value = frame_value | {8'h00, it.data};
            frame_sum   = frame_sum + it.data;
            parse_ph    = PH_SUM;
            cnt_rcv     = cnt_rcv + 16'd1;
          end
          default: begin
            parse_ph = PH_HUNT;
            if (frame_sum == it.data) begin
              dist_latch = frame_value;
              dist_ready = 1'b1;
            end else begin
              cnt_err  = cnt_err + 16'd1;
              err_code = ERR_CHECKSUM;
              evt      = 1'b1;
            end
          end
        endcase
      end else if (ring_level >= 7'(DEPTH)) begin
        cnt_ovf  = cnt_ovf + 16'd1;
        err_code = ERR_OVERFLOW;
        evt      = 1'b1;
      end else begin
        ring[wr_ptr] = it.data;
        wr_ptr       = wr_ptr + 6'd1;
        ring_level   = ring_level + 7'd1;
        cnt_rcv      = cnt_rcv + 16'd1;
      end
    end else if (it.cmd == CMD_POP && ring_level != 0) begin
      got_byte   = ring[rd_ptr];
      rd_ptr     = rd_ptr + 6'd1;
      ring_level = ring_level - 7'd1;
      vld        = 1'b1;
    end
    rdy = dist_ready;
    if (it.cmd == CMD_READ_DIST) dist_ready = 1'b0;
    r.read_valid     = vld;
    r.read_byte      = got_byte;
    r.distance       = dist_latch;
    r.distance_ready = rdy;
    r.recent_err     = err_code;
    r.error_total    = cnt_err;
    r.framing_total  = cnt_frm;
    r.overflow_total = cnt_ovf;
    r.parity_total   = cnt_par;
    r.received_total = cnt_rcv;
    r.error_event    = evt;
    r.fifo_level     = ring_level;
    return r;
  endfunction

  // Offer one event, with burst gaps, and record its status once taken.
  task automatic send_item(rx_item_t it, bit typed, dir_row_t row);
    result_t r;
    if (burst_left == 0) begin
      push = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    push            = 1'b1;
    cmd_i           = it.cmd;
    rx_byte_i       = it.data;
    frame_error_i   = it.fe;
    overrun_error_i = it.oe;
    parity_error_i  = it.pe;
    do @(posedge clk_i); while (full);
    r = predict_status(it);
    if (typed) begin
      r.read_valid     = row.vld;
      r.read_byte      = row.rbyte;
      r.distance       = row.dist_val;
      r.distance_ready = row.rdy;
      r.recent_err     = row.err;
      r.error_event    = row.evt;
      r.fifo_level     = row.lvl;
    end
    pending_status.push_back(r);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_clean(logic [7:0] b);
    rx_item_t it;
    it = '{CMD_RX, b, 1'b0, 1'b0, 1'b0};
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_noise();
    rx_item_t it;
    it.cmd  = cmd_e'($urandom_range(0, 3));
    it.data = 8'($urandom);
    it.fe   = ($urandom_range(0, 3) == 0);
    it.oe   = ($urandom_range(0, 3) == 0);
    it.pe   = ($urandom_range(0, 3) == 0);
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_cmd(cmd_e c);
    rx_item_t it;
    it = '{c, 8'($urandom), 1'b0, 1'b0, 1'b0};
    send_item(it, 1'b0, '0);
  endtask

  // Drain, let the pipeline settle, then write the mode register.
  task automatic set_sensor_mode(logic mode);
    push = 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    sensor_on = mode;
    clear_frame();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic raw_phase(int n, int fill_pct);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < fill_pct) send_clean(8'($urandom));
      else if (pick < 88) send_cmd(CMD_POP);
      else send_noise();
    end
  endtask

  task automatic sensor_phase(int n);
    int target;
    int pick;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] sum;
    rx_item_t   bad;
    target = sent_items + n;
    while (sent_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        hi  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
        lo  = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
        sum = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(hi + lo);
        send_clean(START_MARK);
        send_clean(hi);
        send_clean(lo);
        if ($urandom_range(0, 9) == 0) begin
          bad = '{CMD_RX, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1};
          send_item(bad, 1'b0, '0);
        end
        send_clean(sum);
        pick = $urandom_range(0, 99);
        if (pick < 40) send_cmd(CMD_READ_DIST);
        else if (pick < 55) send_cmd(CMD_POP);
      end else if (pick < 75) begin
        send_clean(START_MARK);
        repeat ($urandom_range(0, 2)) send_clean(8'($urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver stall pattern: switch at random between four pop styles.
  initial begin
    int stall_mode;
    int left;
    int tick;
    pop        = 1'b0;
    stall_mode = 0;
    left       = 0;
    tick       = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        stall_mode = $urandom_range(0, 3);
        left       = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (stall_mode)
        0:       pop = 1'b1;
        1:       pop = 1'($urandom_range(0, 1));
        2:       pop = ($urandom_range(0, 3) == 0);
        default: pop = (tick % 5) > 1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status beat with nothing expected");
      end else begin
        want = pending_status.pop_front();
        compare_field("read_valid", 16'(read_valid_o), 16'(want.read_valid));
        compare_field("read_byte", 16'(read_byte_o), 16'(want.read_byte));
        compare_field("distance", distance_o, want.distance);
        compare_field("distance_ready", 16'(distance_ready_o), 16'(want.distance_ready));
        compare_field("recent_err", 16'(recent_err_o), 16'(want.recent_err));
        compare_field("error_total", error_total_o, want.error_total);
        compare_field("framing_total", framing_total_o, want.framing_total);
        compare_field("overflow_total", overflow_total_o, want.overflow_total);
        compare_field("parity_total", parity_total_o, want.parity_total);
        compare_field("received_total", received_total_o, want.received_total);
        compare_field("error_event", 16'(error_event_o), 16'(want.error_event));
        compare_field("fifo_level", 16'(fifo_level_o), 16'(want.fifo_level));
      end
    end
  end

  initial begin
    rx_item_t it;
    int       waited;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 1'b0;
    push            = 1'b0;
    cmd_i           = CMD_NONE;
    rx_byte_i       = '0;
    frame_error_i   = 1'b0;
    overrun_error_i = 1'b0;
    parity_error_i  = 1'b0;
    mismatches      = 0;
    sent_items      = 0;
    burst_left      = 0;
    rd_ptr          = '0;
    wr_ptr          = '0;
    ring_level      = '0;
    dist_latch      = '0;
    cnt_err         = '0;
    cnt_frm         = '0;
    cnt_ovf         = '0;
    cnt_par         = '0;
    cnt_rcv         = '0;
    err_code        = ERR_NONE;
    sensor_on       = 1'b0;
    clear_frame();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].mode !== sensor_on) set_sensor_mode(dir_rows[i].mode);
      it = '{dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].fe, dir_rows[i].oe,
             dir_rows[i].pe};
      send_item(it, dir_rows[i].typed, dir_rows[i]);
    end

    set_sensor_mode(1'b1);
    sensor_phase(150);
    set_sensor_mode(1'b0);
    raw_phase(200, 75);
    set_sensor_mode(1'b0);
    raw_phase(150, 30);
    set_sensor_mode(1'b1);
    sensor_phase(150);
    set_sensor_mode(1'b1);
    sensor_phase(130);
    set_sensor_mode(1'b0);
    raw_phase(150, 60);
    set_sensor_mode(1'b1);
    sensor_phase(120);
    set_sensor_mode(1'b0);
    raw_phase(100, 80);

    push   = 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_status.size() != 0)
      report_mismatch($sformatf("%0d status beats never arrived", pending_status.size()));
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/urfp_pkg.sv
hw/rtl/urfp_queue.sv
hw/rtl/urfp_front.sv
hw/rtl/urfp_back.sv
hw/rtl/uart_receive_frame_parser_fifo.sv
hw/rtl/urfp_checker.sv
tb/tb_uart_receive_frame_parser_fifo.sv
